@@ rtl/wlls_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wlls_pkg;

    // Default sizes of the worker row.
    localparam int C_WORKERS   = 8;
    localparam int C_LOAD_BITS = 32;

    // Stream and configuration port widths.
    localparam int C_IN_TDATA_W  = 48;
    localparam int C_IN_TUSER_W  = 2;
    localparam int C_OUT_TDATA_W = 8;
    localparam int C_OUT_TUSER_W = 2;
    localparam int C_CFG_INDEX_W = 2;
    localparam int C_CFG_DATA_W  = 64;

    // Request commands.
    localparam logic [1:0] C_CMD_SELECT = 2'd0;
    localparam logic [1:0] C_CMD_REPORT = 2'd1;
    localparam logic [1:0] C_CMD_INIT   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] C_REG_NUM_WORKERS     = 2'd0;
    localparam logic [1:0] C_REG_RECOVER_WAIT    = 2'd1;
    localparam logic [1:0] C_REG_RECOVER_PENALTY = 2'd2;
    localparam logic [1:0] C_REG_INCREMENT_TABLE = 2'd3;

    // Configuration reset values.
    localparam logic [3:0]  C_RST_NUM_WORKERS     = 4'd8;
    localparam logic [15:0] C_RST_RECOVER_WAIT    = 16'd60;
    localparam logic [15:0] C_RST_RECOVER_PENALTY = 16'd320;
    localparam logic [63:0] C_RST_INCREMENT_TABLE = 64'h1010_1010_1010_1010;

    // Operations broadcast to the worker cells when a request commits.
    localparam logic [2:0] C_OP_NONE        = 3'd0;
    localparam logic [2:0] C_OP_SELECT      = 3'd1;
    localparam logic [2:0] C_OP_REPORT_OK   = 3'd2;
    localparam logic [2:0] C_OP_REPORT_FAIL = 3'd3;
    localparam logic [2:0] C_OP_INIT        = 3'd4;

    // Flags that travel along the cell row with a scan.
    typedef struct packed {
        logic busy;       // a scan occupies this stage
        logic valid;      // a worker has been picked so far
        logic probe;      // the pick is a recovery probe; later cells stop looking
        logic route_err;  // the routed worker is in error
    } t_scan_flags;

    // Update broadcast to every cell in the commit cycle.
    typedef struct packed {
        logic [2:0]  op;
        logic        probe;
        logic [31:0] now;
    } t_commit;

endpackage

`default_nettype wire

@@ rtl/wlls_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wlls_cell #(
    parameter int LOAD_BITS = wlls_pkg::C_LOAD_BITS,
    parameter int IDX_BITS  = 3,
    parameter int SLOT      = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [3:0]            i_num_workers,
    input  logic [15:0]           i_recover_wait,
    input  logic [7:0]            i_increment,
    input  logic [31:0]           i_now,
    input  logic [3:0]            i_route,
    input  wlls_pkg::t_scan_flags i_flags,
    input  logic [IDX_BITS-1:0]   i_pick,
    input  logic [LOAD_BITS-1:0]  i_best,
    input  logic [LOAD_BITS-1:0]  i_max,
    output wlls_pkg::t_scan_flags o_flags,
    output logic [IDX_BITS-1:0]   o_pick,
    output logic [LOAD_BITS-1:0]  o_best,
    output logic [LOAD_BITS-1:0]  o_max,
    input  wlls_pkg::t_commit     i_commit,
    input  logic [IDX_BITS-1:0]   i_commit_idx,
    input  logic [LOAD_BITS-1:0]  i_commit_load
);
    import wlls_pkg::*;

    localparam logic [4:0]          L_SLOT5 = 5'(SLOT);
    localparam logic [IDX_BITS-1:0] L_SLOT  = IDX_BITS'(SLOT);

    // Worker state held by this cell.
    logic [LOAD_BITS-1:0] r_load;
    logic                 r_err;
    logic                 r_rec;
    logic [31:0]          r_stamp;

    // Scan stage registers handed to the next cell.
    t_scan_flags          r_flags;
    logic [IDX_BITS-1:0]  r_pick;
    logic [LOAD_BITS-1:0] r_best;
    logic [LOAD_BITS-1:0] r_max;

    t_scan_flags          n_flags;
    logic [IDX_BITS-1:0]  n_pick;
    logic [LOAD_BITS-1:0] n_best;
    logic [LOAD_BITS-1:0] n_max;

    logic                 w_in_use;
    logic                 w_expired;
    logic [31:0]          w_age;
    logic [LOAD_BITS:0]   w_inc_sum;
    logic [LOAD_BITS-1:0] w_inc_load;
    logic                 w_hit;

    assign w_in_use  = L_SLOT5 < {1'b0, i_num_workers};
    assign w_age     = i_now - r_stamp;
    assign w_expired = w_age > {16'd0, i_recover_wait};

    // Saturating increment of this worker's load.
    assign w_inc_sum  = {1'b0, r_load} + (LOAD_BITS + 1)'(i_increment);
    assign w_inc_load = w_inc_sum[LOAD_BITS] ? {LOAD_BITS{1'b1}} : w_inc_sum[LOAD_BITS-1:0];

    // Scan step: probe search, least-load search, healthy maximum, route check.
    always_comb begin
        n_flags = i_flags;
        n_pick  = i_pick;
        n_best  = i_best;
        n_max   = i_max;
        if (w_in_use) begin
            if ({1'b0, i_route} == L_SLOT5) begin
                n_flags.route_err = r_err;
            end
            if (!r_err && (r_load > i_max)) begin
                n_max = r_load;
            end
            if (!i_flags.probe) begin
                if (r_err) begin
                    if (!r_rec && w_expired) begin
                        n_flags.valid = 1'b1;
                        n_flags.probe = 1'b1;
                        n_pick        = L_SLOT;
                    end
                end else if (!i_flags.valid || (r_load < i_best)) begin
                    n_flags.valid = 1'b1;
                    n_pick        = L_SLOT;
                    n_best        = r_load;
                end
            end
        end
    end

    // Stage flags; the busy bit marks where the scan is.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pick <= n_pick;
        r_best <= n_best;
        r_max  <= n_max;
    end

    assign w_hit = i_commit_idx == L_SLOT;

    // Worker state updates from the commit broadcast.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load  <= '0;
            r_err   <= 1'b0;
            r_rec   <= 1'b0;
            r_stamp <= '0;
        end else begin
            case (i_commit.op)
                C_OP_SELECT: begin
                    if (w_hit) begin
                        r_load <= w_inc_load;
                        if (i_commit.probe) begin
                            r_rec   <= 1'b1;
                            r_stamp <= i_commit.now;
                        end
                    end
                end
                C_OP_REPORT_OK: begin
                    if (w_hit) begin
                        if (r_rec) begin
                            r_load <= i_commit_load;
                        end
                        r_err   <= 1'b0;
                        r_rec   <= 1'b0;
                        r_stamp <= '0;
                    end
                end
                C_OP_REPORT_FAIL: begin
                    if (w_hit) begin
                        r_err   <= 1'b1;
                        r_rec   <= 1'b0;
                        r_stamp <= i_commit.now;
                    end
                end
                C_OP_INIT: begin
                    r_load <= (LOAD_BITS)'(i_increment);
                    r_err  <= 1'b0;
                    r_rec  <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_flags = r_flags;
    assign o_pick  = r_pick;
    assign o_best  = r_best;
    assign o_max   = r_max;

endmodule

`default_nettype wire

@@ rtl/weighted_least_load_selector_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Weighted least-load worker selector with failover. Each request either selects a
// backend worker (sticky route, recovery probe of a failed worker whose wait has run
// out, or the healthy worker of least load, lowest index on ties), reports the
// outcome of an attempt on a worker, or reinitialises every load to its increment.
// Worker state lives in a row of WORKERS identical cells; a select or report request
// walks the row one cell per clock, then the row's answer is captured, the update is
// committed and the result loaded, and the sequencer returns to idle before the next
// request is taken. Initialise and unused commands skip the row and go straight to
// commit. One request is in the block at a time; the result register frees the input
// side while a result waits, and a commit is held back only while the previous result
// is still not taken. Every request gives exactly one result; chosen_valid is 0 for
// everything but a successful select. Configuration is written through a plain write
// port; the user is to write it only while the block is idle, which it does not enforce.
module weighted_least_load_selector_core #(
    parameter int WORKERS   = wlls_pkg::C_WORKERS,
    parameter int LOAD_BITS = wlls_pkg::C_LOAD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // now_seconds[31:0], has_route[32], route_worker[36:33], is_retry[37],
    // report_worker[40:38], success[41], zero fill [47:42]
    input  logic [wlls_pkg::C_IN_TDATA_W-1:0]   i_s_tdata,
    // command[1:0]
    input  logic [wlls_pkg::C_IN_TUSER_W-1:0]   i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // chosen_worker[2:0], zero fill [7:3]
    output logic [wlls_pkg::C_OUT_TDATA_W-1:0]  o_m_tdata,
    // chosen_valid[0], is_probe[1]
    output logic [wlls_pkg::C_OUT_TUSER_W-1:0]  o_m_tuser,
    input  logic                                i_cfg_wen,
    input  logic [wlls_pkg::C_CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [wlls_pkg::C_CFG_DATA_W-1:0]   i_cfg_wdata
);
    import wlls_pkg::*;

    localparam int         IW        = $clog2(WORKERS);
    localparam int         EW        = (IW > 3) ? IW : 3;
    localparam logic [4:0] L_WORKERS = 5'(WORKERS);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    // Configuration registers.
    logic [3:0]  r_num_workers;
    logic [15:0] r_recover_wait;
    logic [15:0] r_recover_penalty;
    logic [63:0] r_increment_table;

    // Control.
    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_inject;

    // Held request.
    logic [1:0]  r_cmd;
    logic [31:0] r_now;
    logic        r_has_route;
    logic [3:0]  r_route;
    logic        r_retry;
    logic [2:0]  r_rep;
    logic        r_success;

    // Answer of the cell row.
    t_scan_flags          r_fin_flags;
    logic [IW-1:0]        r_fin_pick;
    logic [LOAD_BITS-1:0] r_fin_max;

    // Result register.
    logic       r_m_tvalid;
    logic       r_out_chosen;
    logic [2:0] r_out_worker;
    logic       r_out_probe;

    // Cell row links.
    t_scan_flags          w_flags [0:WORKERS];
    logic [IW-1:0]        w_pick  [0:WORKERS];
    logic [LOAD_BITS-1:0] w_best  [0:WORKERS];
    logic [LOAD_BITS-1:0] w_max   [0:WORKERS];

    logic                 w_in_acc;
    logic                 w_scan_cmd;
    logic                 w_fire;
    logic                 w_route_ok;
    logic                 w_rep_ok;
    logic [EW-1:0]        w_pick_ext;
    logic [EW-1:0]        w_rep_ext;
    logic [LOAD_BITS:0]   w_pen_sum;
    logic [LOAD_BITS-1:0] w_pen_load;
    t_commit              w_commit;
    t_commit              w_cell_commit;
    logic [IW-1:0]        w_commit_idx;
    logic                 w_res_chosen;
    logic [2:0]           w_res_worker;
    logic                 w_res_probe;

    assign o_s_tready = r_state == S_IDLE;
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_scan_cmd = (i_s_tuser == C_CMD_SELECT) || (i_s_tuser == C_CMD_REPORT);
    assign w_fire     = (r_state == S_COMMIT) && (!r_m_tvalid || i_m_tready);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_workers     <= C_RST_NUM_WORKERS;
            r_recover_wait    <= C_RST_RECOVER_WAIT;
            r_recover_penalty <= C_RST_RECOVER_PENALTY;
            r_increment_table <= C_RST_INCREMENT_TABLE;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                C_REG_NUM_WORKERS:     r_num_workers     <= i_cfg_wdata[3:0];
                C_REG_RECOVER_WAIT:    r_recover_wait    <= i_cfg_wdata[15:0];
                C_REG_RECOVER_PENALTY: r_recover_penalty <= i_cfg_wdata[15:0];
                C_REG_INCREMENT_TABLE: r_increment_table <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Sequencer: idle, scan along the row, commit.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_scan_cmd ? S_SCAN : S_COMMIT;
                end
            end
            S_SCAN: begin
                if (w_flags[WORKERS].busy) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_inject <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_inject <= w_in_acc && w_scan_cmd;
        end
    end

    // Hold the accepted request.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd       <= i_s_tuser;
            r_now       <= i_s_tdata[31:0];
            r_has_route <= i_s_tdata[32];
            r_route     <= i_s_tdata[36:33];
            r_retry     <= i_s_tdata[37];
            r_rep       <= i_s_tdata[40:38];
            r_success   <= i_s_tdata[41];
        end
    end

    // Head of the cell row.
    assign w_flags[0] = '{busy: r_inject, valid: 1'b0, probe: 1'b0, route_err: 1'b0};
    assign w_pick[0]  = '0;
    assign w_best[0]  = '0;
    assign w_max[0]   = '0;

    for (genvar g = 0; g < WORKERS; g++) begin : g_cell
        wlls_cell #(
            .LOAD_BITS (LOAD_BITS),
            .IDX_BITS  (IW),
            .SLOT      (g)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_num_workers  (r_num_workers),
            .i_recover_wait (r_recover_wait),
            .i_increment    (r_increment_table[8 * (g % 8) +: 8]),
            .i_now          (r_now),
            .i_route        (r_route),
            .i_flags        (w_flags[g]),
            .i_pick         (w_pick[g]),
            .i_best         (w_best[g]),
            .i_max          (w_max[g]),
            .o_flags        (w_flags[g + 1]),
            .o_pick         (w_pick[g + 1]),
            .o_best         (w_best[g + 1]),
            .o_max          (w_max[g + 1]),
            .i_commit       (w_cell_commit),
            .i_commit_idx   (w_commit_idx),
            .i_commit_load  (w_pen_load)
        );
    end

    // Capture what leaves the tail of the row.
    always_ff @(posedge i_clk) begin
        if (w_flags[WORKERS].busy) begin
            r_fin_flags <= w_flags[WORKERS];
            r_fin_pick  <= w_pick[WORKERS];
            r_fin_max   <= w_max[WORKERS];
        end
    end

    // Load given to a worker whose probe succeeded, saturating.
    assign w_pen_sum  = {1'b0, r_fin_max} + (LOAD_BITS + 1)'(r_recover_penalty);
    assign w_pen_load = w_pen_sum[LOAD_BITS] ? {LOAD_BITS{1'b1}} : w_pen_sum[LOAD_BITS-1:0];

    assign w_pick_ext = EW'(r_fin_pick);
    assign w_rep_ext  = EW'(r_rep);

    // A route counts only if it names a worker in use and is not a retry onto an
    // erroring worker; reports for workers out of use are dropped.
    assign w_route_ok = r_has_route && (r_route < r_num_workers)
                        && ({1'b0, r_route} < L_WORKERS)
                        && !(r_retry && r_fin_flags.route_err);
    assign w_rep_ok   = ({1'b0, r_rep} < r_num_workers) && (5'(r_rep) < L_WORKERS);

    // Decide the result and the state update of the request.
    always_comb begin
        w_commit       = '{op: C_OP_NONE, probe: 1'b0, now: r_now};
        w_commit_idx   = '0;
        w_res_chosen   = 1'b0;
        w_res_worker   = 3'd0;
        w_res_probe    = 1'b0;
        case (r_cmd)
            C_CMD_SELECT: begin
                if (w_route_ok) begin
                    w_res_chosen = 1'b1;
                    w_res_worker = r_route[2:0];
                end else if (r_fin_flags.valid) begin
                    w_res_chosen   = 1'b1;
                    w_res_worker   = w_pick_ext[2:0];
                    w_res_probe    = r_fin_flags.probe;
                    w_commit.op    = C_OP_SELECT;
                    w_commit.probe = r_fin_flags.probe;
                    w_commit_idx   = r_fin_pick;
                end
            end
            C_CMD_REPORT: begin
                if (w_rep_ok) begin
                    w_commit.op  = r_success ? C_OP_REPORT_OK : C_OP_REPORT_FAIL;
                    w_commit_idx = w_rep_ext[IW-1:0];
                end
            end
            C_CMD_INIT: begin
                w_commit.op = C_OP_INIT;
            end
            default: begin
            end
        endcase
    end

    // The cells see the update only in the cycle the request commits.
    always_comb begin
        w_cell_commit = w_commit;
        if (!w_fire) begin
            w_cell_commit.op = C_OP_NONE;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_fire) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_chosen <= w_res_chosen;
            r_out_worker <= w_res_worker;
            r_out_probe  <= w_res_probe;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {5'd0, r_out_worker};
    assign o_m_tuser  = {r_out_probe, r_out_chosen};

endmodule

`default_nettype wire

@@ rtl/wlls_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wlls_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                i_s_tvalid,
    input wire                                o_s_tready,
    input wire                                o_m_tvalid,
    input wire                                i_m_tready,
    input wire [wlls_pkg::C_OUT_TDATA_W-1:0]  o_m_tdata,
    input wire [wlls_pkg::C_OUT_TUSER_W-1:0]  o_m_tuser
);

    // A probe is always a chosen worker.
    a_probe_is_chosen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> o_m_tuser[0])
        else $error("probe flagged without a chosen worker");

    // With nothing chosen the worker field reads zero.
    a_none_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("worker index given without a choice");

    // One request at a time: no acceptance in the cycle after one.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while another is in progress");

    // A stalled result keeps its contents.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind weighted_least_load_selector_core wlls_checker u_wlls_checker (.*);

`default_nettype wire
